// ===== sv/position_pid_drive_assert.svh =====
`ifndef POSITION_PID_DRIVE_ASSERT_SVH
`define POSITION_PID_DRIVE_ASSERT_SVH

// Check that a condition seen on one edge holds on the same edge.
`define PPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition seen on one edge is followed by another on the next edge.
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ppd_pkg.sv =====
package ppd_pkg;

  // Field and register widths
  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned GAIN_BITS         = 16;
  localparam int unsigned THR_BITS          = 23;
  localparam int unsigned TOUT_BITS         = 16;
  localparam int unsigned SETTLE_BITS       = 4;
  localparam int unsigned LIMIT_BITS        = 15;
  localparam int unsigned POWER_BITS        = 16;
  localparam int unsigned INTEG_BITS        = 40;
  localparam int unsigned CFG_IDX_BITS      = 3;
  localparam int unsigned CFG_DATA_BITS     = 23;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_SETTLE_THR   = 3'd3,
    REG_TIMEOUT      = 3'd4,
    REG_SETTLE_TICKS = 3'd5
  } ppd_reg_e;

  // Register values after reset
  localparam logic signed [GAIN_BITS-1:0] GAIN_P_RST       = 16'sd256;
  localparam logic signed [GAIN_BITS-1:0] GAIN_I_RST       = 16'sd0;
  localparam logic signed [GAIN_BITS-1:0] GAIN_D_RST       = 16'sd0;
  localparam logic [THR_BITS-1:0]         SETTLE_THR_RST   = 23'd10;
  localparam logic [TOUT_BITS-1:0]        TIMEOUT_RST      = 16'd100;
  localparam logic [SETTLE_BITS-1:0]      SETTLE_TICKS_RST = 4'd4;

  // Counter ceilings
  localparam logic [SETTLE_BITS-1:0] SETTLE_MAX  = '1;
  localparam logic [TOUT_BITS-1:0]   ELAPSED_MAX = '1;

  typedef struct packed {
    logic signed [GAIN_BITS-1:0] gain_p;
    logic signed [GAIN_BITS-1:0] gain_i;
    logic signed [GAIN_BITS-1:0] gain_d;
    logic [THR_BITS-1:0]         settle_thr;
    logic [TOUT_BITS-1:0]        timeout;
    logic [SETTLE_BITS-1:0]      settle_ticks;
  } ppd_cfg_t;

  // One result slot; follow marks a done result still owed after this one
  typedef struct packed {
    logic signed [POWER_BITS-1:0] power;
    logic                         done_res;
    logic                         last;
    logic                         follow;
  } ppd_res_t;

endpackage

// ===== sv/ppd_cfg_regs.sv =====
module ppd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ppd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output ppd_pkg::ppd_cfg_t                cfg_o
);
  import ppd_pkg::*;

  ppd_cfg_t cfg_q, cfg_d;

  // Decode the register index and update one field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ppd_reg_e'(cfg_idx_i))
        REG_GAIN_P:       cfg_d.gain_p       = cfg_data_i[GAIN_BITS-1:0];
        REG_GAIN_I:       cfg_d.gain_i       = cfg_data_i[GAIN_BITS-1:0];
        REG_GAIN_D:       cfg_d.gain_d       = cfg_data_i[GAIN_BITS-1:0];
        REG_SETTLE_THR:   cfg_d.settle_thr   = cfg_data_i[THR_BITS-1:0];
        REG_TIMEOUT:      cfg_d.timeout      = cfg_data_i[TOUT_BITS-1:0];
        REG_SETTLE_TICKS: cfg_d.settle_ticks = cfg_data_i[SETTLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p       <= GAIN_P_RST;
      cfg_q.gain_i       <= GAIN_I_RST;
      cfg_q.gain_d       <= GAIN_D_RST;
      cfg_q.settle_thr   <= SETTLE_THR_RST;
      cfg_q.timeout      <= TIMEOUT_RST;
      cfg_q.settle_ticks <= SETTLE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ppd_core.sv =====
module ppd_core #(
  parameter int unsigned POSITION_BITS = ppd_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ppd_pkg::ppd_cfg_t                   cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                start_req_i,
  input  logic signed [POSITION_BITS-1:0]     target_i,
  input  logic [ppd_pkg::LIMIT_BITS-1:0]      speed_limit_i,
  input  logic signed [POSITION_BITS-1:0]     position_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output ppd_pkg::ppd_res_t                   res_o
);
  import ppd_pkg::*;

  localparam int unsigned EB         = POSITION_BITS + 1;
  localparam int unsigned PROD_BITS  = GAIN_BITS + EB;
  localparam int unsigned DIFF_BITS  = EB + 1;
  localparam int unsigned DPROD_BITS = GAIN_BITS + DIFF_BITS;
  localparam int unsigned ISUM_BITS  = ((PROD_BITS > INTEG_BITS) ? PROD_BITS : INTEG_BITS) + 1;
  localparam int unsigned SUM_BITS   = ((DPROD_BITS > INTEG_BITS) ? DPROD_BITS : INTEG_BITS) + 2;
  localparam int unsigned CMP_BITS   = (EB > THR_BITS) ? EB : THR_BITS;

  // Input register
  logic                            in_vld_q;
  logic                            start_q;
  logic signed [POSITION_BITS-1:0] target_q;
  logic [LIMIT_BITS-1:0]           limit_q;
  logic signed [POSITION_BITS-1:0] pos_q;
  logic                            advance;

  // Move state
  logic signed [POSITION_BITS-1:0] ref_q, tgt_q;
  logic [LIMIT_BITS-1:0]           lim_q;
  logic signed [EB-1:0]            prior_q;
  logic signed [INTEG_BITS-1:0]    integ_q;
  logic [SETTLE_BITS-1:0]          sc_q;
  logic [TOUT_BITS-1:0]            el_q;
  logic                            active_q;

  // State as seen by this request, after any start
  logic signed [POSITION_BITS-1:0] ref_e, tgt_e;
  logic [LIMIT_BITS-1:0]           lim_e;
  logic signed [EB-1:0]            prior_e;
  logic signed [INTEG_BITS-1:0]    integ_e;
  logic [SETTLE_BITS-1:0]          sc_e;
  logic [TOUT_BITS-1:0]            el_e;
  logic                            act_e;

  logic signed [GAIN_BITS-1:0]     kp, ki, kd;
  logic signed [POSITION_BITS-1:0] rel;
  logic signed [EB-1:0]            err;
  logic signed [PROD_BITS-1:0]     p_prod, i_prod;
  logic signed [DIFF_BITS-1:0]     diff;
  logic signed [DPROD_BITS-1:0]    d_prod;
  logic signed [ISUM_BITS-1:0]     isum;
  logic                            isum_ovf;
  logic signed [INTEG_BITS-1:0]    integ_n;
  logic signed [SUM_BITS-1:0]      sum, pw_raw, lim_w, pw;
  logic [EB-1:0]                   mag;
  logic                            settled;
  logic [SETTLE_BITS-1:0]          sc_n;
  logic [TOUT_BITS-1:0]            el_n;
  logic                            ending;

  assign advance     = in_vld_q & res_ready_i;
  assign in_stall_o  = in_vld_q & ~res_ready_i;
  assign res_valid_o = in_vld_q;

  // Hold the request until the result slot takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      start_q  <= start_req_i;
      target_q <= target_i;
      limit_q  <= speed_limit_i;
      pos_q    <= position_i;
    end
  end

  // A start replaces the move state before the tick runs
  assign ref_e   = start_q ? pos_q : ref_q;
  assign tgt_e   = start_q ? target_q : tgt_q;
  assign lim_e   = start_q ? limit_q : lim_q;
  assign prior_e = start_q ? '0 : prior_q;
  assign integ_e = start_q ? '0 : integ_q;
  assign sc_e    = start_q ? '0 : sc_q;
  assign el_e    = start_q ? '0 : el_q;
  assign act_e   = start_q | active_q;

  assign kp = cfg_i.gain_p;
  assign ki = cfg_i.gain_i;
  assign kd = cfg_i.gain_d;

  // Error against the reference, relative position wrapping at the field width
  assign rel = pos_q - ref_e;
  assign err = {tgt_e[POSITION_BITS-1], tgt_e} - {rel[POSITION_BITS-1], rel};

  // Three products in parallel
  assign p_prod = kp * err;
  assign i_prod = ki * err;
  assign diff   = {err[EB-1], err} - {prior_e[EB-1], prior_e};
  assign d_prod = kd * diff;

  // Accumulate and saturate the integral
  assign isum     = ISUM_BITS'(integ_e) + ISUM_BITS'(i_prod);
  assign isum_ovf = ~((&isum[ISUM_BITS-1:INTEG_BITS-1]) | ~(|isum[ISUM_BITS-1:INTEG_BITS-1]));
  always_comb begin
    if (isum_ovf) begin
      integ_n = isum[ISUM_BITS-1] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                                  : {1'b0, {(INTEG_BITS-1){1'b1}}};
    end else begin
      integ_n = isum[INTEG_BITS-1:0];
    end
  end

  // Sum, scale down by 256 with floor, clamp to the limit
  assign sum    = SUM_BITS'(p_prod) + SUM_BITS'(integ_n) + SUM_BITS'(d_prod);
  assign pw_raw = sum >>> 8;
  assign lim_w  = SUM_BITS'(lim_e);
  always_comb begin
    if (pw_raw > lim_w) begin
      pw = lim_w;
    end else if (pw_raw < -lim_w) begin
      pw = -lim_w;
    end else begin
      pw = pw_raw;
    end
  end

  // Settle and timeout bookkeeping
  assign mag     = err[EB-1] ? EB'(-err) : EB'(err);
  assign settled = CMP_BITS'(mag) < CMP_BITS'(cfg_i.settle_thr);
  always_comb begin
    if (!settled) begin
      sc_n = '0;
    end else if (sc_e != SETTLE_MAX) begin
      sc_n = sc_e + 1'b1;
    end else begin
      sc_n = sc_e;
    end
  end
  assign el_n   = (el_e != ELAPSED_MAX) ? el_e + 1'b1 : el_e;
  assign ending = (sc_n >= cfg_i.settle_ticks) || (el_e >= cfg_i.timeout);

  // Build the result
  always_comb begin
    if (!act_e) begin
      res_o.power    = '0;
      res_o.done_res = 1'b1;
      res_o.last     = 1'b1;
      res_o.follow   = 1'b0;
    end else begin
      res_o.power    = pw[POWER_BITS-1:0];
      res_o.done_res = 1'b0;
      res_o.last     = ~ending;
      res_o.follow   = ending;
    end
  end

  // Advance the move state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= '0;
      tgt_q    <= '0;
      lim_q    <= '0;
      prior_q  <= '0;
      integ_q  <= '0;
      sc_q     <= '0;
      el_q     <= '0;
      active_q <= 1'b0;
    end else if (advance) begin
      if (start_q) begin
        ref_q <= pos_q;
        tgt_q <= target_q;
        lim_q <= limit_q;
      end
      if (act_e) begin
        prior_q  <= err;
        integ_q  <= integ_n;
        sc_q     <= sc_n;
        el_q     <= el_n;
        active_q <= ~ending;
      end
    end
  end

endmodule

// ===== sv/ppd_out_buf.sv =====
module ppd_out_buf (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  res_valid_i,
  output logic                                  res_ready_o,
  input  ppd_pkg::ppd_res_t                     res_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ppd_pkg::POWER_BITS-1:0] power_o,
  output logic                                  done_res_o,
  output logic                                  last_o
);
  import ppd_pkg::*;

  logic     vld_q, vld_d;
  ppd_res_t res_q, res_d;
  logic     pop, load;

  assign pop         = vld_q & ~out_stall_i;
  assign res_ready_o = ~vld_q | (pop & ~res_q.follow);
  assign load        = res_valid_i & res_ready_o;

  // Load a new result, or turn an ending result into its done result
  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (load) begin
      vld_d = 1'b1;
      res_d = res_i;
    end else if (pop) begin
      if (res_q.follow) begin
        res_d.power    = '0;
        res_d.done_res = 1'b1;
        res_d.last     = 1'b1;
        res_d.follow   = 1'b0;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      res_q <= '0;
    end else begin
      vld_q <= vld_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign power_o     = res_q.power;
  assign done_res_o  = res_q.done_res;
  assign last_o      = res_q.last;

endmodule

// ===== sv/position_pid_drive.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid_i/in_stall_o | start_req_i, target_i, speed_limit_i,
//          |                      | position_i
// output   | out_valid_o/out_stall_i | power_o, done_res_o, last_o
// config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A request is registered, runs through the PID arithmetic combinationally
// and lands in the result register. One request per cycle is taken while
// the output does not stall; a move's ending request yields a second, done
// result, so the result register takes no new result until that is taken.
// Reset clears the move state, the register file to its defaults and both
// valid flags. A stall on the output backs up through the result register
// into the input register and then onto in_stall_o.
module position_pid_drive #(
  parameter int unsigned POSITION_BITS = ppd_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ppd_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [ppd_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  start_req_i,
  input  logic signed [POSITION_BITS-1:0]       target_i,
  input  logic [ppd_pkg::LIMIT_BITS-1:0]        speed_limit_i,
  input  logic signed [POSITION_BITS-1:0]       position_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ppd_pkg::POWER_BITS-1:0] power_o,
  output logic                                  done_res_o,
  output logic                                  last_o
);
  import ppd_pkg::*;

  ppd_cfg_t cfg;
  ppd_res_t res;
  logic     res_valid, res_ready;

  ppd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ppd_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_req_i   (start_req_i),
    .target_i      (target_i),
    .speed_limit_i (speed_limit_i),
    .position_i    (position_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  ppd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .power_o     (power_o),
    .done_res_o  (done_res_o),
    .last_o      (last_o)
  );

endmodule

// ===== sv/ppd_checker.sv =====
`include "position_pid_drive_assert.svh"

module ppd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] power_o,
  input logic               done_res_o,
  input logic               last_o
);

  // A done result drives no power
  `PPD_ASSERT_NOW(a_done_no_power, clk_i, rst_ni, out_valid_o && done_res_o, power_o == 16'h0000, "done result with power")

  // A done result always closes its request
  `PPD_ASSERT_NOW(a_done_is_last, clk_i, rst_ni, out_valid_o && done_res_o, last_o, "done result not last")

  // An ending result taken is followed at once by the done result
  `PPD_ASSERT_NEXT(a_end_then_done, clk_i, rst_ni, out_valid_o && !last_o && !out_stall_i, out_valid_o && done_res_o && last_o, "done result missing after ending result")

  // The clamp keeps power inside plus or minus 32767
  `PPD_ASSERT_NOW(a_power_range, clk_i, rst_ni, out_valid_o, power_o != 16'h8000, "power outside clamp range")

endmodule

bind position_pid_drive ppd_checker u_ppd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .power_o     (power_o),
  .done_res_o  (done_res_o),
  .last_o      (last_o)
);

// ===== tb/position_pid_drive_tb.sv =====
module position_pid_drive_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppd_pkg::*;

  localparam int unsigned PB = POSITION_BITS_DEF;
  localparam longint INTEG_MAX = (longint'(1) << 39) - 1;
  localparam longint INTEG_MIN = -(longint'(1) << 39);
  localparam int LONG_HOLD = 300;

  // One control tick as offered on the input channel
  typedef struct packed {
    logic                 start;
    logic signed [PB-1:0] target;
    logic [LIMIT_BITS-1:0] limit;
    logic signed [PB-1:0] position;
  } move_req_t;

  // One drive command as seen on the output channel
  typedef struct packed {
    logic signed [POWER_BITS-1:0] power;
    logic                         done;
    logic                         last;
  } drive_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     cfg_we = 1'b0;
  ppd_reg_e                 cfg_idx = REG_GAIN_P;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  move_req_t                cur_req = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [POWER_BITS-1:0] power;
  logic                     done_res;
  logic                     last;

  move_req_t  tick_q[$];
  drive_res_t power_due_q[$];
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  drive_res_t want;

  // Register copy and loop state of the predictor
  ppd_cfg_t cfg = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, SETTLE_THR_RST, TIMEOUT_RST,
                    SETTLE_TICKS_RST};
  logic signed [PB-1:0]   ref_pos = '0;
  logic signed [PB-1:0]   tgt = '0;
  logic [LIMIT_BITS-1:0]  lim = '0;
  logic signed [PB:0]     prev_err = '0;
  logic signed [INTEG_BITS-1:0] integ = '0;
  logic [SETTLE_BITS-1:0] settle_cnt = '0;
  logic [TOUT_BITS-1:0]   elapsed = '0;
  logic                   running = 1'b0;

  position_pid_drive dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .start_req_i   (cur_req.start),
    .target_i      (cur_req.target),
    .speed_limit_i (cur_req.limit),
    .position_i    (cur_req.position),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .power_o       (power),
    .done_res_o    (done_res),
    .last_o        (last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Idle length: mostly short, now and then long
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Run one control tick and queue the drive commands it produces
  task automatic pid_tick(input move_req_t rq);
    logic signed [PB-1:0] rel;
    longint err, acc, drive_sum, pw, mag, lim_l, thr_l, gp, gi, gd;
    logic ending;
    drive_res_t r;
    if (rq.start) begin
      tgt = rq.target;
      lim = rq.limit;
      ref_pos = rq.position;
      prev_err = '0;
      integ = '0;
      settle_cnt = '0;
      elapsed = '0;
      running = 1'b1;
    end
    if (!running) begin
      r = '{power: '0, done: 1'b1, last: 1'b1};
      power_due_q.push_back(r);
      return;
    end
    gp = $signed(cfg.gain_p);
    gi = $signed(cfg.gain_i);
    gd = $signed(cfg.gain_d);
    lim_l = lim;
    thr_l = cfg.settle_thr;
    rel = rq.position - ref_pos;
    err = longint'(tgt) - longint'(rel);
    // accumulate and saturate the integral
    acc = longint'(integ) + gi * err;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ = acc[INTEG_BITS-1:0];
    drive_sum = gp * err + acc + gd * (err - longint'(prev_err));
    pw = drive_sum >>> 8;
    if (pw > lim_l) pw = lim_l;
    if (pw < -lim_l) pw = -lim_l;
    prev_err = err[PB:0];
    // count settled ticks
    mag = (err < 0) ? -err : err;
    if (mag < thr_l) begin
      if (settle_cnt != SETTLE_MAX) settle_cnt++;
    end else begin
      settle_cnt = '0;
    end
    ending = (settle_cnt >= cfg.settle_ticks) || (elapsed >= cfg.timeout);
    if (elapsed != ELAPSED_MAX) elapsed++;
    r = '{power: pw[POWER_BITS-1:0], done: 1'b0, last: !ending};
    power_due_q.push_back(r);
    if (ending) begin
      r = '{power: '0, done: 1'b1, last: 1'b1};
      power_due_q.push_back(r);
      running = 1'b0;
    end
  endtask

  // Driver: hold the request while stalled, advance after acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_stall === 1'b0) pid_tick(cur_req);
      if (!in_valid || in_stall === 1'b0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_req <= tick_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= ($urandom_range(0, 99) < tx_idle_pct) ? pick_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then pick the next stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (power_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result power %0d done %b last %b",
                                    power, done_res, last));
        end else begin
          want = power_due_q.pop_front();
          if (power !== want.power || done_res !== want.done || last !== want.last)
            report_mismatch($sformatf("got power %0d done %b last %b, wanted %0d %b %b",
                                      power, done_res, last, want.power, want.done,
                                      want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (hold_ask != hold_seen) begin
        hold_seen <= hold_ask;
        stall_left <= LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        stall_left <= pick_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void queue_tick(input logic st, input longint t, input longint l,
                                     input longint p);
    move_req_t rq;
    rq.start = st;
    rq.target = t[PB-1:0];
    rq.limit = l[LIMIT_BITS-1:0];
    rq.position = p[PB-1:0];
    tick_q.push_back(rq);
  endfunction

  // A move: start, approach the target, then hover near it
  function automatic int queue_move();
    longint t, base, p, nz, l;
    logic signed [PB-1:0] tv;
    int r, nt, half;
    r = $urandom_range(0, 99);
    tv = PB'($urandom());
    if (r < 20) t = tv;
    else if (r < 35) t = longint'($urandom_range(0, 40)) - 20;
    else t = longint'($urandom_range(0, 4000)) - 2000;
    r = $urandom_range(0, 99);
    if (r < 15) l = $urandom_range(0, 50);
    else if (r < 30) l = $urandom_range(0, 32767);
    else l = $urandom_range(100, 32767);
    tv = PB'($urandom());
    base = tv;
    nt = $urandom_range(2, 30);
    half = nt / 2;
    nz = ($urandom_range(0, 9) == 0) ? 200 : 3;
    queue_tick(1'b1, t, l, base);
    for (int k = 1; k <= nt; k++) begin
      if (k < half) p = base + t * k / half;
      else p = base + t + longint'($urandom_range(0, 2 * nz)) - nz;
      queue_tick(1'b0, $urandom(), $urandom(), p);
    end
    return nt + 1;
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    int g;
    if ($urandom_range(0, 99) < 25) return GAIN_BITS'($urandom());
    g = $urandom_range(0, 1024);
    g = g - 256;
    return g[GAIN_BITS-1:0];
  endfunction

  task automatic write_reg(input ppd_reg_e idx, input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P:       cfg.gain_p = val[GAIN_BITS-1:0];
      REG_GAIN_I:       cfg.gain_i = val[GAIN_BITS-1:0];
      REG_GAIN_D:       cfg.gain_d = val[GAIN_BITS-1:0];
      REG_SETTLE_THR:   cfg.settle_thr = val[THR_BITS-1:0];
      REG_TIMEOUT:      cfg.timeout = val[TOUT_BITS-1:0];
      REG_SETTLE_TICKS: cfg.settle_ticks = val[SETTLE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input ppd_cfg_t c);
    write_reg(REG_GAIN_P, CFG_DATA_BITS'(c.gain_p));
    write_reg(REG_GAIN_I, CFG_DATA_BITS'(c.gain_i));
    write_reg(REG_GAIN_D, CFG_DATA_BITS'(c.gain_d));
    write_reg(REG_SETTLE_THR, CFG_DATA_BITS'(c.settle_thr));
    write_reg(REG_TIMEOUT, CFG_DATA_BITS'(c.timeout));
    write_reg(REG_SETTLE_TICKS, CFG_DATA_BITS'(c.settle_ticks));
  endtask

  // Wait for every request to be taken and every result to come back
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || power_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    ppd_cfg_t c;
    int n, r, w, nb;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 30;
    rx_idle_pct = 30;

    // reset settings: idle ticks, position wrap, restart, settle ending
    queue_tick(1'b0, 8388607, 32767, -8388608);
    queue_tick(1'b0, -8388608, 0, 8388607);
    queue_tick(1'b1, 8388607, 32767, -8388608);
    queue_tick(1'b0, 0, 0, 8388607);
    queue_tick(1'b1, -8388608, 0, 0);
    repeat (4) queue_tick(1'b0, 0, 0, -8388608);
    queue_tick(1'b0, 8388607, 32767, 8388607);
    wait_drained();

    // extreme gains, no settling, integral driven into both rails
    set_cfg('{16'sh8000, 16'sh7FFF, 16'sh8000, 23'd0, 16'hFFFF, 4'd15});
    queue_tick(1'b1, -8388608, 32767, 0);
    queue_tick(1'b0, 0, 0, 8388607);
    queue_tick(1'b0, 0, 0, -8388608);
    queue_tick(1'b0, 0, 0, 8388607);
    queue_tick(1'b1, 8388607, 32767, 0);
    queue_tick(1'b0, 0, 0, -8388608);
    queue_tick(1'b0, 0, 0, -8388608);
    wait_drained();

    // zero timeout and zero settle count end the move on its first tick
    set_cfg('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 23'h7FFFFF, 16'd0, 4'd0});
    queue_tick(1'b1, 8388607, 32767, -1234);
    queue_tick(1'b0, 0, 0, 55);
    wait_drained();

    // timeout after one finished tick
    set_cfg('{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, 23'd0, 16'd1, 4'd15});
    queue_tick(1'b1, 500, 300, 100);
    queue_tick(1'b0, 0, 0, 150);
    queue_tick(1'b0, 0, 0, 150);
    wait_drained();

    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      c.gain_p = pick_gain();
      c.gain_i = pick_gain();
      c.gain_d = pick_gain();
      r = $urandom_range(0, 99);
      if (r < 80) c.settle_thr = THR_BITS'($urandom_range(1, 60));
      else if (r < 90) c.settle_thr = '0;
      else c.settle_thr = THR_BITS'($urandom());
      r = $urandom_range(0, 99);
      if (r < 75) c.timeout = TOUT_BITS'($urandom_range(3, 60));
      else if (r < 85) c.timeout = TOUT_BITS'($urandom_range(0, 2));
      else c.timeout = TOUT_BITS'($urandom());
      r = $urandom_range(0, 99);
      if (r < 80) c.settle_ticks = SETTLE_BITS'($urandom_range(1, 8));
      else if (r < 90) c.settle_ticks = ($urandom_range(0, 1) != 0) ? 4'd15 : 4'd0;
      else c.settle_ticks = SETTLE_BITS'($urandom());
      set_cfg(c);

      tx_idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
      rx_idle_pct = (ph % 4 == 1) ? 0 : $urandom_range(10, 50);
      if (ph == 2) tx_idle_pct = 0;

      n = 0;
      while (n < 93) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          n += queue_move();
        end else if (r < 90) begin
          // noise: ticks with arbitrary content
          queue_tick($urandom_range(0, 9) == 0, $urandom(), $urandom(), $urandom());
          n++;
        end else begin
          // broken move: start, then positions that jump about
          nb = $urandom_range(1, 5);
          queue_tick(1'b1, $urandom(), $urandom(), $urandom());
          repeat (nb) queue_tick(1'b0, $urandom(), $urandom(), $urandom());
          n += nb + 1;
        end
      end
      // hold off the receiver while the sender keeps offering
      if (ph == 2) hold_ask++;
      wait_drained();
    end

    // drain with a bound, then let the pipeline settle
    w = 0;
    while (w < 50000 && (tick_q.size() != 0 || in_valid || power_due_q.size() != 0)) begin
      w++;
      @(posedge clk_i);
    end
    if (power_due_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", power_due_q.size()));
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
